### rtl/core/slipc_pkg.sv
// ----------------------------------------------------------------------------
// slipc_pkg
// shared constants and the job descriptor passed from front to back
// ----------------------------------------------------------------------------
package slipc_pkg;

  // slip special bytes
  localparam logic [7:0] SLIP_END  = 8'hC0;
  localparam logic [7:0] SLIP_ESC  = 8'hDB;
  localparam logic [7:0] SLIP_TEND = 8'hDC;
  localparam logic [7:0] SLIP_TESC = 8'hDD;
  localparam logic [7:0] ASCII_C   = 8'h43;

  // command codes carried in the input tuser
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // register word index
  localparam logic REG_ESCAPE_ASCII_C = 1'b0;

  localparam int CNT_W       = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam int OUT_TDATA_W = 48;
  localparam int MAX_RESULTS = 4;

  // one input transaction's worth of results
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  last_idx;
    logic                        byte_valid;
    logic                        frame_end;
    logic [CNT_W-1:0]            frame_length;
    logic                        bad_escape;
    logic [CNT_W-1:0]            error_total;
  } job_t;

endpackage

### rtl/core/slipc_front.sv
// ----------------------------------------------------------------------------
// slipc_front
// accepts input transactions, runs the codec state and builds result jobs
// ----------------------------------------------------------------------------
module slipc_front
  import slipc_pkg::*;
#(
  parameter int LENGTH_MAX = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tuser,   // command
  input  logic       in_tlast,   // last_byte
  input  logic       escape_ascii_c,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(LENGTH_MAX);

  logic             enc_open_r, enc_open_nxt;
  logic             dec_esc_r, dec_esc_nxt;
  logic [CNT_W-1:0] dec_len_r, dec_len_nxt;
  logic [CNT_W-1:0] err_cnt_r, err_cnt_nxt;
  logic             has_result;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && has_result;

  always_comb begin
    logic [1:0] k;
    logic [7:0] b;
    k            = 2'd0;
    b            = in_tdata;
    enc_open_nxt = enc_open_r;
    dec_esc_nxt  = dec_esc_r;
    dec_len_nxt  = dec_len_r;
    err_cnt_nxt  = err_cnt_r;
    has_result   = 1'b0;
    q_job        = '0;
    q_job.error_total = err_cnt_r;
    unique case (in_tuser)
      CMD_ENCODE: begin
        has_result       = 1'b1;
        q_job.byte_valid = 1'b1;
        if (!enc_open_r) begin
          q_job.bytes[k] = SLIP_END;
          k              = k + 2'd1;
          enc_open_nxt   = 1'b1;
        end
        if (b == SLIP_ESC || b == SLIP_END || (b == ASCII_C && escape_ascii_c)) begin
          q_job.bytes[k] = SLIP_ESC;
          k              = k + 2'd1;
          if (b == SLIP_ESC) q_job.bytes[k] = SLIP_TESC;
          else if (b == SLIP_END) q_job.bytes[k] = SLIP_TEND;
          else q_job.bytes[k] = ASCII_C;
        end else begin
          q_job.bytes[k] = b;
        end
        q_job.last_idx = k;
        if (in_tlast) begin
          k              = k + 2'd1;
          q_job.bytes[k] = SLIP_END;
          q_job.last_idx = k;
          enc_open_nxt   = 1'b0;
        end
      end
      CMD_DECODE: begin
        unique case (b)
          SLIP_END: begin
            has_result         = (dec_len_r != '0);
            q_job.frame_end    = 1'b1;
            q_job.frame_length = dec_len_r;
            dec_len_nxt        = '0;
            dec_esc_nxt        = 1'b0;
          end
          SLIP_ESC: begin
            dec_esc_nxt = 1'b1;
          end
          default: begin
            has_result       = 1'b1;
            q_job.byte_valid = 1'b1;
            q_job.bytes[0]   = b;
            if (dec_esc_r) begin
              dec_esc_nxt = 1'b0;
              if (b == SLIP_TESC) q_job.bytes[0] = SLIP_ESC;
              else if (b == SLIP_TEND) q_job.bytes[0] = SLIP_END;
              else begin
                q_job.bad_escape = 1'b1;
                if (err_cnt_r != CNT_MAX) err_cnt_nxt = err_cnt_r + 1'b1;
              end
            end
            q_job.error_total = err_cnt_nxt;
            if (dec_len_r < LEN_LIMIT) dec_len_nxt = dec_len_r + 1'b1;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_open_r <= 1'b0;
      dec_esc_r  <= 1'b0;
      dec_len_r  <= '0;
      err_cnt_r  <= '0;
    end else if (accept) begin
      enc_open_r <= enc_open_nxt;
      dec_esc_r  <= dec_esc_nxt;
      dec_len_r  <= dec_len_nxt;
      err_cnt_r  <= err_cnt_nxt;
    end
  end

endmodule

### rtl/core/slipc_queue.sv
// ----------------------------------------------------------------------------
// slipc_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module slipc_queue
  import slipc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

### rtl/core/slipc_back.sv
// ----------------------------------------------------------------------------
// slipc_back
// walks the current job and presents one result transaction per cycle while out_tready is high
// ----------------------------------------------------------------------------
module slipc_back
  import slipc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  job_t                   q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  job_t       cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       take_next;

  assign at_last    = (idx_r == cur_r.last_idx);
  assign take_next  = !busy_r || (out_tready && at_last);
  assign q_pop      = take_next && !q_empty;
  assign out_tvalid = busy_r;
  assign out_tlast  = at_last;
  assign out_tdata  = {5'd0, cur_r.error_total, cur_r.bad_escape, cur_r.frame_length,
                       cur_r.frame_end, cur_r.byte_valid, cur_r.bytes[idx_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (take_next) begin
      busy_r <= !q_empty;
      idx_r  <= 2'd0;
    end else if (out_tready) begin
      idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
  end

endmodule

### rtl/core/slip_framing_codec.sv
// ----------------------------------------------------------------------------
// slip_framing_codec
// byte-wise slip framing encoder and decoder with an apb register port
// ----------------------------------------------------------------------------
// Each input transaction is one byte and a command: encode (tuser 0) turns a
// packet byte into one to four line bytes, opening the packet with 0xC0,
// escaping 0xC0 and 0xDB (and ASCII C when escape_ascii_c is set) and closing
// with 0xC0 after the byte flagged by tlast; decode (tuser 1) takes one line
// byte and gives at most one result: a decoded byte, or the length of a frame
// that a 0xC0 just ended (empty frames and escape bytes give nothing). The
// front accepts one transaction per cycle while its two-entry job queue has
// room; the back emits one result per cycle while out_tready is high, so an
// item that causes n results holds the back until all n are out, and an item
// with no result only takes its turn at the input. Output is the limit: one
// result transaction per cycle while out_tready is high; a plain byte in an
// open packet gives one result, an escaped byte that opens and closes four.
// Register 0 at byte address 0: escape_ascii_c in bit 0.
// ----------------------------------------------------------------------------
module slip_framing_codec
  import slipc_pkg::*;
#(
  parameter int LENGTH_MAX = 65535
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] data_byte
  input  logic                   in_tuser,    // [0] command
  input  logic                   in_tlast,    // last_byte
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] out_byte, [8] byte_valid, [9] frame_end, [25:10] frame_length,
  // [26] bad_escape, [42:27] error_total, [47:43] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // run_last
  // register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic escape_ascii_c_r;
  logic cfg_wr;
  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // register port: no wait states, word index in paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ESCAPE_ASCII_C) ? {31'd0, escape_ascii_c_r}
                                                           : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_ascii_c_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == REG_ESCAPE_ASCII_C) begin
      escape_ascii_c_r <= cfg_pwdata[0];
    end
  end

  // front: classification and codec state
  slipc_front #(
    .LENGTH_MAX (LENGTH_MAX)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .escape_ascii_c (escape_ascii_c_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // job queue decouples input stalls from output stalls
  slipc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  // back: result sequencing, one transaction per cycle while out_tready is high
  slipc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/core/slipc_checker.sv
// ----------------------------------------------------------------------------
// slipc_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module slipc_checker
  import slipc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a result without a byte is a frame report and ends its run
  a_frame_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[9] && out_tlast && out_tdata[25:10] != 16'd0)
    else $error("bad frame report");

  // a frame report never carries a byte or a bad escape
  a_frame_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8] && !out_tdata[26])
    else $error("frame end mixed with byte");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:43] == 5'd0)
    else $error("pad bits set");

  // nothing pending straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind slip_framing_codec slipc_checker u_checker (.*);

### sim/slip_codec_checker.sv
// ----------------------------------------------------------------------------
// slip_codec_checker
// watches the slip codec's channels, predicts its results and compares them
// ----------------------------------------------------------------------------
module slip_codec_checker
  import slipc_pkg::*;
#(
  parameter int LENGTH_MAX = 65535
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  input  logic [31:0]            cfg_prdata,
  input  logic                   cfg_pready,
  output int                     fail_total,
  output int                     results_waiting
);

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             frame_end;
    logic [CNT_W-1:0] frame_length;
    logic             bad_escape;
    logic [CNT_W-1:0] error_total;
    logic             run_last;
  } slip_result_t;

  localparam logic [2:0] ESC_C_ADDR = {REG_ESCAPE_ASCII_C, 2'b00};

  slip_result_t     results_due[$];
  logic             escape_c_mode;
  logic             enc_open;
  logic             dec_escaped;
  logic [CNT_W-1:0] dec_length;
  logic [CNT_W-1:0] bad_escape_count;
  int               fail_count;

  function automatic slip_result_t line_byte(input logic [7:0] b);
    slip_result_t r;
    r = '0;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.error_total = bad_escape_count;
    return r;
  endfunction

  function automatic string show_result(input slip_result_t r);
    return $sformatf("byte %02h valid %0b end %0b len %0d bad %0b errors %0d last %0b",
                     r.out_byte, r.byte_valid, r.frame_end, r.frame_length,
                     r.bad_escape, r.error_total, r.run_last);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // one accepted input transaction: update the codec state, queue its results
  task automatic slip_codec_step(input logic cmd, input logic [7:0] b_in, input logic last);
    slip_result_t     step_out[MAX_RESULTS];
    int               n;
    logic [7:0]       b;
    logic             bad;
    logic [CNT_W-1:0] len;
    n   = 0;
    b   = b_in;
    bad = 1'b0;
    if (cmd == CMD_ENCODE) begin
      if (!enc_open) begin
        step_out[n] = line_byte(SLIP_END);
        n++;
        enc_open = 1'b1;
      end
      if (b == SLIP_ESC) begin
        step_out[n] = line_byte(SLIP_ESC);
        step_out[n+1] = line_byte(SLIP_TESC);
        n += 2;
      end else if (b == SLIP_END) begin
        step_out[n] = line_byte(SLIP_ESC);
        step_out[n+1] = line_byte(SLIP_TEND);
        n += 2;
      end else if (b == ASCII_C && escape_c_mode) begin
        step_out[n] = line_byte(SLIP_ESC);
        step_out[n+1] = line_byte(ASCII_C);
        n += 2;
      end else begin
        step_out[n] = line_byte(b);
        n++;
      end
      if (last) begin
        step_out[n] = line_byte(SLIP_END);
        n++;
        enc_open = 1'b0;
      end
    end else begin
      if (b == SLIP_END) begin
        // frame end always drops a pending escape; empty frames report nothing
        len         = dec_length;
        dec_length  = '0;
        dec_escaped = 1'b0;
        if (len != 0) begin
          step_out[n] = line_byte(8'h00);
          step_out[n].byte_valid   = 1'b0;
          step_out[n].frame_end    = 1'b1;
          step_out[n].frame_length = len;
          n++;
        end
      end else if (b == SLIP_ESC) begin
        dec_escaped = 1'b1;
      end else begin
        if (dec_escaped) begin
          dec_escaped = 1'b0;
          if (b == SLIP_TESC) begin
            b = SLIP_ESC;
          end else if (b == SLIP_TEND) begin
            b = SLIP_END;
          end else begin
            bad = 1'b1;
            if (bad_escape_count != CNT_MAX) begin
              bad_escape_count++;
            end
          end
        end
        if (dec_length < LENGTH_MAX) begin
          dec_length++;
        end
        step_out[n] = line_byte(b);
        step_out[n].bad_escape = bad;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        step_out[i].run_last = 1'b1;
      end
      results_due.push_back(step_out[i]);
    end
  endtask

  always @(posedge clk) begin
    slip_result_t got;
    slip_result_t want;
    if (!rst_n) begin
      escape_c_mode    = 1'b0;
      enc_open         = 1'b0;
      dec_escaped      = 1'b0;
      dec_length       = '0;
      bad_escape_count = '0;
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ESC_C_ADDR) begin
        if (cfg_pwrite) begin
          escape_c_mode = cfg_pwdata[0];
        end else if (cfg_prdata !== {31'b0, escape_c_mode}) begin
          note_failure($sformatf("register read: expected %08h, got %08h",
                                 {31'b0, escape_c_mode}, cfg_prdata));
        end
      end
      if (in_tvalid && in_tready) begin
        slip_codec_step(in_tuser, in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        got.out_byte     = out_tdata[7:0];
        got.byte_valid   = out_tdata[8];
        got.frame_end    = out_tdata[9];
        got.frame_length = out_tdata[25:10];
        got.bad_escape   = out_tdata[26];
        got.error_total  = out_tdata[42:27];
        got.run_last     = out_tlast;
        if (results_due.size() == 0) begin
          note_failure({"unexpected result: ", show_result(got)});
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            note_failure({"result mismatch\n  expected ", show_result(want),
                          "\n  actual   ", show_result(got)});
          end
        end
      end
    end
    fail_total      <= fail_count;
    results_waiting <= results_due.size();
  end

  initial begin
    fail_count = 0;
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the slip framing codec
// ----------------------------------------------------------------------------
// Drives encode and decode transactions into the codec: a short directed run
// over the special bytes, then batches of random packets, line frames (some
// with broken escapes) and noise under changing escape_ascii_c settings. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import slipc_pkg::*;

  localparam int LENGTH_MAX    = 65535;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam int BATCH_ITEMS   = 38;
  localparam int BATCHES       = 6;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;    // [7:0] data_byte
  logic                   in_tuser;    // [0] command
  logic                   in_tlast;    // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] out_byte, [8] byte_valid, [9] frame_end, [25:10] frame_length,
  // [26] bad_escape, [42:27] error_total, [47:43] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;   // run_last
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [2:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  int   fail_total;
  int   results_waiting;
  int   items_sent = 0;
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic hold_arm   = 1'b0;
  int   hold_left  = 0;

  slip_framing_codec #(
    .LENGTH_MAX (LENGTH_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  slip_codec_checker #(
    .LENGTH_MAX (LENGTH_MAX)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fail_total      (fail_total),
    .results_waiting (results_waiting)
  );

  // 4 unit period, high then low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off when armed so that
  // the codec's job queue fills and it has to stall the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 13);
    end
  end

  // biased toward the bytes that the framing treats specially
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return SLIP_END;
      1:       return SLIP_ESC;
      2:       return ASCII_C;
      3:       return SLIP_TEND;
      4:       return SLIP_TESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one transaction and hold it until the codec takes it
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= cmd;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait until every predicted result is out, then let the codec settle before
  // going on
  task automatic settle();
    while (results_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; address of the only register
  task automatic cfg_access(input logic write, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {REG_ESCAPE_ASCII_C, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // codec idle first, then write escape_ascii_c and read it back
  task automatic set_escape_c(input logic mode);
    settle();
    cfg_access(1'b1, {31'($urandom), mode});
    cfg_access(1'b0, 32'h0);
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(CMD_ENCODE, pick_byte(), i == len - 1);
    end
  endtask

  // a line frame built from a random packet, with some broken escapes mixed in
  task automatic send_line_frame(input int len);
    logic [7:0] b;
    if ($urandom_range(0, 1)) begin
      send_item(CMD_DECODE, SLIP_END, 1'($urandom));
    end
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      if ($urandom_range(0, 99) < 12) begin
        send_item(CMD_DECODE, SLIP_ESC, 1'($urandom));
        send_item(CMD_DECODE, 8'($urandom_range(0, 255)), 1'($urandom));
      end else if (b == SLIP_END) begin
        send_item(CMD_DECODE, SLIP_ESC, 1'($urandom));
        send_item(CMD_DECODE, SLIP_TEND, 1'($urandom));
      end else if (b == SLIP_ESC) begin
        send_item(CMD_DECODE, SLIP_ESC, 1'($urandom));
        send_item(CMD_DECODE, SLIP_TESC, 1'($urandom));
      end else begin
        send_item(CMD_DECODE, b, 1'($urandom));
      end
    end
    send_item(CMD_DECODE, SLIP_END, 1'($urandom));
  endtask

  // run limit, reckoned well above the slowest correct run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int         batch_start;
    int         roll;
    // every input known from the start
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = CMD_ENCODE;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'b000;
    cfg_pwdata  = 32'h0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: encoder special bytes with the c escape off
    set_escape_c(1'b0);
    send_item(CMD_ENCODE, 8'h00, 1'b0);      // opens the packet
    send_item(CMD_ENCODE, 8'hFF, 1'b0);
    send_item(CMD_ENCODE, SLIP_END, 1'b0);
    send_item(CMD_ENCODE, SLIP_ESC, 1'b0);
    send_item(CMD_ENCODE, ASCII_C, 1'b1);    // plain c, then close
    send_item(CMD_ENCODE, SLIP_END, 1'b1);   // open, escape and close at once
    // directed: decoder
    send_item(CMD_DECODE, SLIP_END, 1'b1);   // empty frame, nothing out
    send_item(CMD_DECODE, 8'h00, 1'b0);
    send_item(CMD_DECODE, 8'hFF, 1'b1);
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);
    send_item(CMD_DECODE, SLIP_TEND, 1'b0);
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);
    send_item(CMD_DECODE, SLIP_TESC, 1'b0);
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);
    send_item(CMD_DECODE, 8'h41, 1'b0);      // bad escape
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);   // second escape only re-arms
    send_item(CMD_DECODE, SLIP_TEND, 1'b0);
    send_item(CMD_DECODE, SLIP_ESC, 1'b0);
    send_item(CMD_DECODE, SLIP_END, 1'b0);   // frame end drops the escape
    send_item(CMD_DECODE, SLIP_TEND, 1'b0);  // so this passes as itself
    send_item(CMD_DECODE, SLIP_END, 1'b0);
    stop_sending();
    // directed: c escape on
    set_escape_c(1'b1);
    send_item(CMD_ENCODE, ASCII_C, 1'b1);
    send_item(CMD_ENCODE, 8'h44, 1'b1);
    stop_sending();

    // random batches, each under its own setting
    for (int batch = 0; batch < BATCHES; batch++) begin
      set_escape_c(batch < 2 ? 1'(batch) : 1'($urandom));
      // one long receiver hold-off while the sender keeps going
      if (batch == 1) begin
        hold_arm = 1'b1;
      end
      tx_idle_en = (batch != 2);
      rx_idle_en = (batch != 2);
      batch_start = items_sent;
      while (items_sent - batch_start < BATCH_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          send_packet($urandom_range(1, 6));
        end else if (roll < 80) begin
          send_line_frame($urandom_range(1, 8));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom), 8'($urandom_range(0, 255)), 1'($urandom));
          end
        end
      end
      stop_sending();
    end

    settle();
    if (fail_total == 0 && results_waiting == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
